// ----- rtl/swac_pkg.sv -----
// Shared command codes and status types for the signed word ALU.
`default_nettype none

package swac_pkg;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    // Packed so that ovf sits in bit 0 of the output tuser
    typedef struct packed {
        logic zero_div;
        logic ovf;
    } t_flags;

endpackage

`default_nettype wire

// ----- rtl/swac_unit.sv -----
// Shared add/subtract unit used by the add/subtract, negation, run and fix-up steps of the sequencer.
`default_nettype none

module swac_unit #(
    parameter int WIDTH = 30
) (
    input  wire logic [WIDTH-1:0] i_a,
    input  wire logic [WIDTH-1:0] i_b,
    input  wire logic             i_sub,
    output logic      [WIDTH-1:0] o_sum
);

    // single carry chain: a + ~b + 1 when subtracting
    assign o_sum = i_a + (i_b ^ {WIDTH{i_sub}}) + WIDTH'(i_sub);

endmodule

`default_nettype wire

// ----- rtl/swac_outreg.sv -----
// Output register stage holding one finished result for the master side.
`default_nettype none

module swac_outreg #(
    parameter int WORD_BITS = 15
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    output logic                      o_space,
    input  wire logic [WORD_BITS-1:0] i_result,
    input  wire swac_pkg::t_flags     i_flags,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic      [WORD_BITS-1:0] o_result,
    output swac_pkg::t_flags          o_flags
);

    logic                 r_valid;
    logic [WORD_BITS-1:0] r_result;
    swac_pkg::t_flags     r_flags;
    logic                 w_take;

    assign o_space = !r_valid || i_ready;
    assign w_take  = i_load && o_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_result <= i_result;
            r_flags  <= i_flags;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_flags  = r_flags;

endmodule

`default_nettype wire

// ----- rtl/signed_word_alu_checked.sv -----
// Top level: sequencer and datapath of the checked signed word ALU.
//
//  channel | dir | tdata (low bit up)                    | tuser (low bit up)
//  --------+-----+---------------------------------------+--------------------------
//  s_axis  | in  | left_operand, right_operand, zero pad | command
//  m_axis  | out | result_word, zero pad                 | overflow_flag, zero_divide_flag
//
// Add and subtract go through the ADDSUB and DONE states from acceptance to the output register.
// Multiply and divide go through two operand negations, setup, one shift-add or
// restoring-subtract step per bit through the shared adder, fix-up and hand-off;
// divide by zero, a most negative dividend or divisor and a most negative multiplier
// skip the steps. The next item can be taken in the cycle after hand-off.
// s_axis_tready is high only while the sequencer is idle; a result waiting on
// m_axis blocks only the next hand-off. Reset is synchronous, active low.
`default_nettype none

module signed_word_alu_checked #(
    parameter int WORD_BITS = 15
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // left_operand, right_operand, zero pad
    input  wire logic [((2*WORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // command
    input  wire logic [1:0]                            s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // result_word, zero pad
    output logic      [((WORD_BITS+7)/8)*8-1:0]        m_axis_tdata,
    // overflow_flag, zero_divide_flag
    output logic      [1:0]                            m_axis_tuser
);

    localparam int AW = 2 * WORD_BITS;
    localparam int CW = $clog2(WORD_BITS);
    localparam int OUT_W = ((WORD_BITS + 7) / 8) * 8;
    localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [WORD_BITS-1:0] WORD_ONE = WORD_BITS'(1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADDSUB = 3'd1;
    localparam logic [2:0] S_NEG_A  = 3'd2;
    localparam logic [2:0] S_NEG_B  = 3'd3;
    localparam logic [2:0] S_SETUP  = 3'd4;
    localparam logic [2:0] S_RUN    = 3'd5;
    localparam logic [2:0] S_FIX    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]           r_state, n_state;
    logic [1:0]           r_cmd;
    logic [WORD_BITS-1:0] r_a, r_b, r_na, r_nb;
    logic [AW-1:0]        r_acc, r_mcand;
    logic [WORD_BITS-1:0] r_dq;
    logic [CW-1:0]        r_cnt;
    logic                 r_flip;
    logic [WORD_BITS-1:0] r_res;
    swac_pkg::t_flags     r_flags;

    logic [AW-1:0]        w_ua, w_ub, w_sum;
    logic                 w_usub;
    logic                 w_accept;
    logic                 w_out_space;
    logic                 w_a_neg, w_b_neg, w_b_min;
    logic [WORD_BITS-1:0] w_x, w_k;
    logic [AW-1:0]        w_div_sh;
    logic [AW-WORD_BITS:0] w_hi;
    logic [WORD_BITS-1:0] w_out_res;
    swac_pkg::t_flags     w_out_flags;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_a_neg  = r_a[WORD_BITS-1];
    assign w_b_neg  = r_b[WORD_BITS-1];
    assign w_b_min  = (r_b == WORD_MIN);
    // multiplier operands after moving the sign of the right operand across
    assign w_x      = w_b_neg ? r_na : r_a;
    assign w_k      = w_b_neg ? r_nb : r_b;
    assign w_div_sh = {r_acc[AW-2:0], r_dq[WORD_BITS-1]};
    assign w_hi     = r_acc[AW-1:WORD_BITS-1];

    always_comb begin
        w_ua   = '0;
        w_ub   = '0;
        w_usub = 1'b0;
        unique case (r_state)
            S_ADDSUB: begin
                w_ua   = {{(AW-WORD_BITS){r_a[WORD_BITS-1]}}, r_a};
                w_ub   = {{(AW-WORD_BITS){r_b[WORD_BITS-1]}}, r_b};
                // negating the most negative word yields itself, so it is added
                w_usub = (r_cmd == swac_pkg::CMD_SUB) && !w_b_min;
            end
            S_NEG_A: begin
                w_ub   = {{(AW-WORD_BITS){1'b0}}, r_a};
                w_usub = 1'b1;
            end
            S_NEG_B: begin
                w_ub   = {{(AW-WORD_BITS){1'b0}}, r_b};
                w_usub = 1'b1;
            end
            S_RUN: begin
                if (r_cmd == swac_pkg::CMD_MUL) begin
                    w_ua = r_acc;
                    w_ub = r_mcand;
                end else begin
                    w_ua   = w_div_sh;
                    w_ub   = r_mcand;
                    w_usub = 1'b1;
                end
            end
            S_FIX: begin
                w_ub   = {{(AW-WORD_BITS){1'b0}}, r_dq};
                w_usub = 1'b1;
            end
            S_IDLE, S_SETUP, S_DONE: begin
                w_usub = 1'b0;
            end
        endcase
    end

    swac_unit #(
        .WIDTH (AW)
    ) u_unit (
        .i_a   (w_ua),
        .i_b   (w_ub),
        .i_sub (w_usub),
        .o_sum (w_sum)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser == swac_pkg::CMD_ADD || s_axis_tuser == swac_pkg::CMD_SUB)
                        n_state = S_ADDSUB;
                    else
                        n_state = S_NEG_A;
                end
            end
            S_ADDSUB: n_state = S_DONE;
            S_NEG_A:  n_state = S_NEG_B;
            S_NEG_B:  n_state = S_SETUP;
            S_SETUP: begin
                if (r_cmd == swac_pkg::CMD_MUL)
                    n_state = w_b_min ? S_DONE : S_RUN;
                else if (r_b == '0 || r_a == WORD_MIN || w_b_min)
                    n_state = S_DONE;
                else
                    n_state = S_RUN;
            end
            S_RUN:  n_state = (r_cnt == '0) ? S_FIX : S_RUN;
            S_FIX:  n_state = S_DONE;
            S_DONE: n_state = w_out_space ? S_IDLE : S_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_cmd <= s_axis_tuser;
                    r_a   <= s_axis_tdata[WORD_BITS-1:0];
                    r_b   <= s_axis_tdata[2*WORD_BITS-1:WORD_BITS];
                end
            end
            S_ADDSUB: begin
                r_res         <= w_sum[WORD_BITS-1:0];
                r_flags.ovf      <= w_sum[WORD_BITS] ^ w_sum[WORD_BITS-1];
                r_flags.zero_div <= 1'b0;
            end
            S_NEG_A: r_na <= w_sum[WORD_BITS-1:0];
            S_NEG_B: r_nb <= w_sum[WORD_BITS-1:0];
            S_SETUP: begin
                r_flags.ovf      <= 1'b0;
                r_flags.zero_div <= (r_cmd == swac_pkg::CMD_DIV) && (r_b == '0);
                r_acc   <= '0;
                r_cnt   <= CW'(WORD_BITS - 1);
                r_flip  <= w_a_neg ^ w_b_neg;
                if (r_cmd == swac_pkg::CMD_MUL) begin
                    r_mcand <= {{(AW-WORD_BITS){w_x[WORD_BITS-1]}}, w_x};
                    r_dq    <= w_k;
                    r_res   <= '0;
                end else begin
                    r_mcand <= {{(AW-WORD_BITS){1'b0}}, (w_b_neg ? r_nb : r_b)};
                    r_dq    <= w_a_neg ? r_na : r_a;
                    if (r_b != '0 && r_a == WORD_MIN) begin
                        // magnitude counts as -1, so the sign is applied here: -1 for a negative divisor, else 1
                        r_res <= w_b_neg ? {WORD_BITS{1'b1}} : WORD_ONE;
                    end else begin
                        r_res <= '0;
                    end
                end
            end
            S_RUN: begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cmd == swac_pkg::CMD_MUL) begin
                    if (r_dq[0])
                        r_acc <= w_sum;
                    r_mcand <= {r_mcand[AW-2:0], 1'b0};
                    r_dq    <= {1'b0, r_dq[WORD_BITS-1:1]};
                end else begin
                    // restoring step: keep the difference when it did not go negative
                    r_acc <= w_sum[AW-1] ? w_div_sh : w_sum;
                    r_dq  <= {r_dq[WORD_BITS-2:0], !w_sum[AW-1]};
                end
            end
            S_FIX: begin
                if (r_cmd == swac_pkg::CMD_MUL) begin
                    r_res       <= r_acc[WORD_BITS-1:0];
                    r_flags.ovf <= !((&w_hi) || !(|w_hi));
                end else begin
                    r_res <= r_flip ? w_sum[WORD_BITS-1:0] : r_dq;
                end
            end
            S_DONE: begin
                r_res <= r_res;
            end
        endcase
    end

    swac_outreg #(
        .WORD_BITS (WORD_BITS)
    ) u_outreg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_state == S_DONE),
        .o_space  (w_out_space),
        .i_result (r_res),
        .i_flags  (r_flags),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_out_res),
        .o_flags  (w_out_flags)
    );

    assign m_axis_tdata = OUT_W'(w_out_res);
    assign m_axis_tuser = w_out_flags;

endmodule

`default_nettype wire

// ----- rtl/swac_checker.sv -----
// Port-level checker for the signed word ALU, bound to the top level.
`default_nettype none

module swac_checker #(
    parameter int WORD_BITS = 15
) (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [((WORD_BITS+7)/8)*8-1:0]   m_axis_tdata,
    input wire logic [1:0]                       m_axis_tuser
);

    // a stalled result holds until the transaction completes
    a_out_hold: assert property (@(posedge i_clk)
        (i_rst_n && m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    // the block works on one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk)
        (i_rst_n && s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while busy");

    // zero divide never reports overflow and always gives a zero word
    a_zero_div_clean: assert property (@(posedge i_clk)
        (m_axis_tvalid && m_axis_tuser[1]) |->
            (!m_axis_tuser[0] && m_axis_tdata[WORD_BITS-1:0] == '0))
        else $error("zero divide result not clean");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind signed_word_alu_checked swac_checker #(
    .WORD_BITS (WORD_BITS)
) u_swac_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- tb/sv/alu_checker.sv -----
// Checker for the signed word ALU: predicts each result and compares it on the output stream.
`timescale 1ns / 100ps

module alu_checker #(
    parameter int WORD_BITS = 15,
    parameter int IN_BITS   = ((2*WORD_BITS+7)/8)*8,
    parameter int OUT_BITS  = ((WORD_BITS+7)/8)*8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_tvalid,
    input  logic                i_in_tready,
    // left_operand, right_operand, zero pad
    input  logic [IN_BITS-1:0]  i_in_tdata,
    // command
    input  logic [1:0]          i_in_tuser,
    input  logic                i_out_tvalid,
    input  logic                i_out_tready,
    // result_word, zero pad
    input  logic [OUT_BITS-1:0] i_out_tdata,
    // overflow_flag, zero_divide_flag
    input  logic [1:0]          i_out_tuser,
    output int                  o_errors,
    output int                  o_pending
);

    localparam int MSB = WORD_BITS - 1;

    typedef logic [WORD_BITS-1:0] t_word;

    localparam t_word MOST_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam t_word MOST_POS = ~MOST_NEG;

    typedef struct packed {
        logic [1:0]       cmd;
        t_word            left;
        t_word            right;
        t_word            word;
        swac_pkg::t_flags flags;
    } t_alu_result;

    t_alu_result awaited_results[$];

    function automatic t_word negate(t_word w);
        return -w;
    endfunction

    function automatic t_word add_checked(t_word a, t_word b, output logic ovf);
        t_word s;
        s   = a + b;
        ovf = (a[MSB] == b[MSB]) && (s[MSB] != a[MSB]);
        return s;
    endfunction

    function automatic t_alu_result predict_alu_result(logic [1:0] cmd, t_word a, t_word b);
        t_alu_result r;
        logic                     ovf;
        t_word                    k, x, mx, limit, ma, mb, q;
        logic [2*WORD_BITS-1:0]   prod;
        logic                     flip;
        r       = '0;
        r.cmd   = cmd;
        r.left  = a;
        r.right = b;
        ovf     = 1'b0;
        case (cmd)
            swac_pkg::CMD_ADD: begin
                r.word = add_checked(a, b, ovf);
            end
            swac_pkg::CMD_SUB: begin
                // negating the most negative value leaves it unchanged, so it is added
                r.word = add_checked(a, negate(b), ovf);
            end
            swac_pkg::CMD_MUL: begin
                if (b == MOST_NEG) begin
                    r.word = '0;
                end else begin
                    if (b[MSB]) begin
                        k = negate(b);
                        x = negate(a);
                    end else begin
                        k = b;
                        x = a;
                    end
                    if (k != '0) begin
                        if (x[MSB]) begin
                            mx    = negate(x);
                            limit = MOST_NEG / k;
                        end else begin
                            mx    = x;
                            limit = MOST_POS / k;
                        end
                        ovf = (mx > limit);
                    end
                    prod   = {{WORD_BITS{1'b0}}, x} * {{WORD_BITS{1'b0}}, k};
                    r.word = prod[WORD_BITS-1:0];
                end
            end
            default: begin
                if (b == '0) begin
                    r.flags.zero_div = 1'b1;
                    r.word           = '0;
                end else begin
                    flip = a[MSB] ^ b[MSB];
                    ma   = a[MSB] ? negate(a) : a;
                    mb   = b[MSB] ? negate(b) : b;
                    // a most negative dividend keeps its sign bit after negation
                    if (ma[MSB])
                        q = '1;
                    else if (mb[MSB])
                        q = '0;
                    else
                        q = ma / mb;
                    r.word = flip ? negate(q) : q;
                end
            end
        endcase
        r.flags.ovf = ovf;
        return r;
    endfunction

    task automatic note_failure(string what);
        o_errors = o_errors + 1;
        if (o_errors <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin : watch
        t_alu_result exp;
        t_word       got_word;
        logic        got_ovf, got_zd;
        if (i_rst_n) begin
            if (i_in_tvalid && i_in_tready)
                awaited_results.push_back(predict_alu_result(i_in_tuser,
                    i_in_tdata[WORD_BITS-1:0], i_in_tdata[2*WORD_BITS-1:WORD_BITS]));
            if (i_out_tvalid && i_out_tready) begin
                got_word = i_out_tdata[WORD_BITS-1:0];
                got_ovf  = i_out_tuser[0];
                got_zd   = i_out_tuser[1];
                if (awaited_results.size() == 0) begin
                    note_failure($sformatf("unexpected transaction word %h ovf %b zdiv %b",
                        got_word, got_ovf, got_zd));
                end else begin
                    exp = awaited_results.pop_front();
                    if (got_word !== exp.word || got_ovf !== exp.flags.ovf
                            || got_zd !== exp.flags.zero_div)
                        note_failure($sformatf(
                            "cmd %0d a %h b %h: expected word %h ovf %b zdiv %b, got %h %b %b",
                            exp.cmd, exp.left, exp.right, exp.word, exp.flags.ovf,
                            exp.flags.zero_div, got_word, got_ovf, got_zd));
                end
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

// ----- tb/sv/tb_signed_word_alu_checked.sv -----
// Testbench top for the signed word ALU: stimulus, back-pressure and the verdict.
`timescale 1ns / 100ps

module tb_signed_word_alu_checked;

    localparam int WORD_BITS = 15;
    localparam int IN_BITS   = ((2*WORD_BITS+7)/8)*8;
    localparam int OUT_BITS  = ((WORD_BITS+7)/8)*8;
    localparam int PHASE_ITEMS = 200;

    typedef logic [WORD_BITS-1:0] t_word;

    localparam t_word W_MIN  = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam t_word W_MAX  = ~W_MIN;
    localparam t_word W_ONES = '1;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata;
    logic [1:0]          s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_BITS-1:0] m_axis_tdata;
    logic [1:0]          m_axis_tuser;

    int errors;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;

    signed_word_alu_checked #(
        .WORD_BITS(WORD_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    alu_checker #(
        .WORD_BITS(WORD_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .i_out_tuser  (m_axis_tuser),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = swac_pkg::CMD_ADD;
        m_axis_tready  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    end

    always #1 i_clk = ~i_clk;

    // receiver back-pressure
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    task automatic send_op(logic [1:0] cmd, t_word a, t_word b);
        logic [IN_BITS-1:0] payload;
        payload = '0;
        payload[WORD_BITS-1:0]           = a;
        payload[2*WORD_BITS-1:WORD_BITS] = b;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= payload;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // operand mix weighted toward the corners of the word range
    function automatic t_word pick_operand();
        case ($urandom_range(0, 9))
            0:       return W_MIN;
            1:       return W_MAX;
            2:       return '0;
            3:       return t_word'(1);
            4:       return W_ONES;
            5:       return t_word'(int'($urandom_range(0, 15)) - 8);
            default: return t_word'($urandom);
        endcase
    endfunction

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic random_phase(int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (PHASE_ITEMS)
            send_op(2'($urandom_range(0, 3)), pick_operand(), pick_operand());
        drain_results();
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // corner cases, no idling
        send_op(swac_pkg::CMD_ADD, W_MAX, t_word'(1));
        send_op(swac_pkg::CMD_ADD, W_MIN, W_ONES);
        send_op(swac_pkg::CMD_ADD, W_MIN, W_MIN);
        send_op(swac_pkg::CMD_ADD, W_MAX, W_MAX);
        send_op(swac_pkg::CMD_ADD, '0, '0);
        send_op(swac_pkg::CMD_SUB, '0, W_MIN);
        send_op(swac_pkg::CMD_SUB, t_word'(5), W_MIN);
        send_op(swac_pkg::CMD_SUB, W_MIN, t_word'(1));
        send_op(swac_pkg::CMD_SUB, W_MAX, W_ONES);
        send_op(swac_pkg::CMD_MUL, W_MAX, t_word'(2));
        send_op(swac_pkg::CMD_MUL, W_MIN, W_ONES);
        send_op(swac_pkg::CMD_MUL, t_word'(3), W_MIN);
        send_op(swac_pkg::CMD_MUL, W_MIN, W_MIN);
        send_op(swac_pkg::CMD_MUL, W_ONES, W_ONES);
        send_op(swac_pkg::CMD_MUL, t_word'(181), t_word'(181));
        send_op(swac_pkg::CMD_MUL, t_word'(127), t_word'(129));
        send_op(swac_pkg::CMD_MUL, t_word'(-128), t_word'(128));
        send_op(swac_pkg::CMD_DIV, t_word'(7), '0);
        send_op(swac_pkg::CMD_DIV, W_MIN, t_word'(1));
        send_op(swac_pkg::CMD_DIV, W_MIN, W_ONES);
        send_op(swac_pkg::CMD_DIV, W_MIN, W_MIN);
        send_op(swac_pkg::CMD_DIV, t_word'(5), W_MIN);
        send_op(swac_pkg::CMD_DIV, t_word'(-7), t_word'(2));
        send_op(swac_pkg::CMD_DIV, t_word'(7), t_word'(-2));
        send_op(swac_pkg::CMD_DIV, W_MAX, W_MAX);
        // sender holds off until every result is back
        drain_results();

        random_phase(0, 0);
        random_phase(71, 0);
        random_phase(0, 71);
        random_phase(16, 16);

        recv_stall_pct = 0;
        repeat (30) @(negedge i_clk);
        if (errors == 0 && pending == 0)
            $display("PASS signed_word_alu_checked");
        else
            $display("FAIL signed_word_alu_checked");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL signed_word_alu_checked");
        $finish;
    end

endmodule
